>>> hw/rtl/vnf_pkg.sv
// ============================================================================
// vnf_pkg
// Shared constants, types and register codes for the value-noise fBM block.
// ============================================================================
package vnf_pkg;

  // texture and lattice geometry
  localparam int TEX_BITS  = 8;                    // TEX_SIZE = 256
  localparam int PIX_W     = 8;
  localparam int OCT_CNT   = 4;
  localparam int BWRAP_W   = 5;
  localparam int WRAP_W    = BWRAP_W + OCT_CNT - 1;
  localparam int PXS_W     = PIX_W + WRAP_W;
  localparam int Q16_W     = 16;
  localparam int FRAC_PAD  = Q16_W - TEX_BITS;

  // corner hash multipliers
  localparam logic [31:0] HASH_KX = 32'd374761393;
  localparam logic [31:0] HASH_KY = 32'd668265263;
  localparam logic [31:0] HASH_KS = 32'd1013904223;
  localparam logic [31:0] HASH_KM = 32'd1274126177;

  // smoothstep: 3.0 in Q2.16
  localparam logic [17:0] SMOOTH_K3 = 18'd196608;

  // normalization: floor(T*255 / DENOM), DENOM = 2*65535*(2^OCT_CNT - 1)
  localparam int          SUM_W     = Q16_W + OCT_CNT + 1;
  localparam int          PRD_W     = SUM_W + 8;
  localparam longint      DENOM     = 64'd2 * 64'd65535 * ((64'd1 << OCT_CNT) - 64'd1);
  localparam int          RCP_SHIFT = 40;
  localparam longint      RECIP     = (64'd1 << RCP_SHIFT) / DENOM;
  localparam int          RCP_W     = $clog2(RECIP + 1);
  localparam int          DEN_W     = $clog2(DENOM + 1);
  localparam int          EST_W     = 9;

  localparam logic [31:0] SEED_RST  = 32'd4242;
  localparam logic [BWRAP_W-1:0] BWRAP_RST = BWRAP_W'(4);

  // configuration register index
  typedef enum logic [0:0] {
    CFG_NOISE_SEED = 1'b0,
    CFG_BASE_WRAP  = 1'b1
  } cfg_idx_t;

  typedef logic [Q16_W-1:0] q16_t;
  typedef q16_t [OCT_CNT-1:0] oct_vec_t;

endpackage

>>> hw/rtl/vnf_octave.sv
// ============================================================================
// vnf_octave
// One noise octave: lattice map, four corner hashes, smoothstep, bilinear blend.
// Five register stages, no stall.
// ============================================================================
module vnf_octave (
  input  logic                              clk,
  input  logic [vnf_pkg::PIX_W-1:0]         in_pixel_x,
  input  logic [vnf_pkg::PIX_W-1:0]         in_pixel_y,
  input  logic [vnf_pkg::WRAP_W-1:0]        wrap_i,
  input  logic [31:0]                       seed_i,
  output vnf_pkg::q16_t                     n_o
);

  // stage 1: scaled coordinates, seed term
  logic [vnf_pkg::PXS_W-1:0]  pxs_r, pys_r;
  logic [vnf_pkg::WRAP_W-1:0] wrap_r;
  logic [31:0]                seed_term_r;

  always_ff @(posedge clk) begin
    pxs_r       <= vnf_pkg::PXS_W'(in_pixel_x) * vnf_pkg::PXS_W'(wrap_i);
    pys_r       <= vnf_pkg::PXS_W'(in_pixel_y) * vnf_pkg::PXS_W'(wrap_i);
    wrap_r      <= wrap_i;
    seed_term_r <= seed_i * vnf_pkg::HASH_KS;
  end

  // stage 2: lattice corners, first hash sum, t squared
  logic [vnf_pkg::WRAP_W-1:0] ix, iy, cx1, cy1;
  logic [vnf_pkg::WRAP_W:0]   ix_inc, iy_inc;
  vnf_pkg::q16_t              tx, ty;
  logic [31:0]                hx0, hx1, hy0, hy1;
  logic [31:0]                h0_r [4];
  logic [31:0]                ttx_r, tty_r;
  vnf_pkg::q16_t              tx_r, ty_r;

  always_comb begin
    ix     = pxs_r[vnf_pkg::PXS_W-1 -: vnf_pkg::WRAP_W];
    iy     = pys_r[vnf_pkg::PXS_W-1 -: vnf_pkg::WRAP_W];
    tx     = {pxs_r[vnf_pkg::TEX_BITS-1:0], vnf_pkg::FRAC_PAD'(0)};
    ty     = {pys_r[vnf_pkg::TEX_BITS-1:0], vnf_pkg::FRAC_PAD'(0)};
    ix_inc = {1'b0, ix} + 1'b1;
    iy_inc = {1'b0, iy} + 1'b1;
    // wrap: index+1 reaching the wrap folds to 0; zero wrap pins all corners
    cx1 = (wrap_r == '0 || ix_inc == {1'b0, wrap_r}) ? '0 : ix_inc[vnf_pkg::WRAP_W-1:0];
    cy1 = (wrap_r == '0 || iy_inc == {1'b0, wrap_r}) ? '0 : iy_inc[vnf_pkg::WRAP_W-1:0];
    hx0 = 32'(ix)  * vnf_pkg::HASH_KX;
    hx1 = 32'(cx1) * vnf_pkg::HASH_KX;
    hy0 = 32'(iy)  * vnf_pkg::HASH_KY;
    hy1 = 32'(cy1) * vnf_pkg::HASH_KY;
  end

  always_ff @(posedge clk) begin
    h0_r[0] <= hx0 + hy0 + seed_term_r;
    h0_r[1] <= hx1 + hy0 + seed_term_r;
    h0_r[2] <= hx0 + hy1 + seed_term_r;
    h0_r[3] <= hx1 + hy1 + seed_term_r;
    ttx_r   <= 32'(tx) * 32'(tx);
    tty_r   <= 32'(ty) * 32'(ty);
    tx_r    <= tx;
    ty_r    <= ty;
  end

  // stage 3: hash mix multiply, smoothstep
  logic [31:0]   m_r [4];
  logic [17:0]   kx, ky;
  logic [49:0]   smx, smy;
  vnf_pkg::q16_t sx_r, sy_r;

  always_comb begin
    kx  = vnf_pkg::SMOOTH_K3 - {1'b0, tx_r, 1'b0};
    ky  = vnf_pkg::SMOOTH_K3 - {1'b0, ty_r, 1'b0};
    smx = 50'(ttx_r) * 50'(kx);
    smy = 50'(tty_r) * 50'(ky);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      m_r[k] <= (h0_r[k] ^ (h0_r[k] >> 13)) * vnf_pkg::HASH_KM;
    end
    sx_r <= smx[47:32];
    sy_r <= smy[47:32];
  end

  // stage 4: corner values, blend along x
  vnf_pkg::q16_t crn [4];
  logic [16:0]   wx_inv;
  logic [32:0]   ab_sum, cd_sum;
  vnf_pkg::q16_t ab_r, cd_r, sy_d_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      crn[k] = m_r[k][15:0] ^ m_r[k][31:16];
    end
    wx_inv = 17'h10000 - 17'(sx_r);
    ab_sum = 33'(crn[0]) * 33'(wx_inv) + 33'(crn[1]) * 33'(sx_r);
    cd_sum = 33'(crn[2]) * 33'(wx_inv) + 33'(crn[3]) * 33'(sx_r);
  end

  always_ff @(posedge clk) begin
    ab_r   <= ab_sum[31:16];
    cd_r   <= cd_sum[31:16];
    sy_d_r <= sy_r;
  end

  // stage 5: blend along y
  logic [16:0]   wy_inv;
  logic [32:0]   n_sum;
  vnf_pkg::q16_t n_r;

  always_comb begin
    wy_inv = 17'h10000 - 17'(sy_d_r);
    n_sum  = 33'(ab_r) * 33'(wy_inv) + 33'(cd_r) * 33'(sy_d_r);
  end

  always_ff @(posedge clk) begin
    n_r <= n_sum[31:16];
  end

  assign n_o = n_r;

endmodule

>>> hw/rtl/vnf_norm.sv
// ============================================================================
// vnf_norm
// Octave sum, scale by 255 / (sum of weights times 65535) via reciprocal, clamp.
// Three register stages ending in the output register.
// ============================================================================
module vnf_norm (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 vld_i,
  input  vnf_pkg::oct_vec_t    n_i,
  output logic                 out_valid,
  output logic [7:0]           out_noise_value
);

  // stage 1: weighted sum times 255
  logic [vnf_pkg::SUM_W-1:0] tot;
  logic [vnf_pkg::PRD_W-1:0] q_r;
  logic                      v1_r;

  always_comb begin
    tot = '0;
    for (int i = 0; i < vnf_pkg::OCT_CNT; i++) begin
      tot = tot + (vnf_pkg::SUM_W'(n_i[i]) << (vnf_pkg::OCT_CNT - i));
    end
  end

  always_ff @(posedge clk) begin
    q_r <= vnf_pkg::PRD_W'(tot) * vnf_pkg::PRD_W'(255);
  end

  // stage 2: reciprocal estimate, equal to quotient or one below
  localparam int RP_W = vnf_pkg::PRD_W + vnf_pkg::RCP_W;
  logic [RP_W-1:0]            rp;
  logic [vnf_pkg::EST_W-1:0]  est_r;
  logic [vnf_pkg::PRD_W-1:0]  q2_r;
  logic                       v2_r;

  assign rp = RP_W'(q_r) * RP_W'(vnf_pkg::RECIP);

  always_ff @(posedge clk) begin
    est_r <= vnf_pkg::EST_W'(rp >> vnf_pkg::RCP_SHIFT);
    q2_r  <= q_r;
  end

  // stage 3: remainder check, clamp
  logic [vnf_pkg::PRD_W-1:0]  rem;
  logic [vnf_pkg::EST_W-1:0]  quo;
  logic [7:0]                 val_nxt;
  logic [7:0]                 val_r;
  logic                       v3_r;

  always_comb begin
    rem = q2_r - vnf_pkg::PRD_W'(vnf_pkg::PRD_W'(est_r) * vnf_pkg::PRD_W'(vnf_pkg::DENOM));
    quo = (rem >= vnf_pkg::PRD_W'(vnf_pkg::DENOM)) ? est_r + 1'b1 : est_r;
    val_nxt = (quo > vnf_pkg::EST_W'(255)) ? 8'hff : quo[7:0];
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= vld_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign out_valid       = v3_r;
  assign out_noise_value = val_r;

`ifndef NO_ASSERTIONS
  a_vld_lat: assert property (@(posedge clk) disable iff (!rst_n)
    vld_i |-> ##3 out_valid) else $error("result strobe lost");
  a_no_spur: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_i |-> ##3 !out_valid) else $error("spurious result strobe");
  a_est_rng: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> est_r <= vnf_pkg::EST_W'(255)) else $error("reciprocal estimate too high");
  a_rst_clr: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("strobe after reset");
`endif

endmodule

>>> hw/rtl/value_noise_fbm_generator.sv
// ============================================================================
// value_noise_fbm_generator
// Four-octave tileable value-noise fBM: one texel coordinate in, one byte out.
// ============================================================================
// Throughput: one request per cycle; busy is never raised.
// Depth is set by the octave datapath (5 stages: scale, hash sum, hash mix /
// smoothstep, x blend, y blend) and normalization (3 stages).
// Reset (rst_n low, synchronous) clears the stage valid bits and loads
// noise_seed = 4242, base_wrap = 4. No results are lost since out is unstalled.
module value_noise_fbm_generator (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            start,
  output logic                            busy,
  input  logic [vnf_pkg::PIX_W-1:0]       in_pixel_x,
  input  logic [vnf_pkg::PIX_W-1:0]       in_pixel_y,
  // result channel
  output logic                            out_valid,
  output logic [7:0]                      out_noise_value,
  // config write port
  input  logic                            cfg_we,
  input  vnf_pkg::cfg_idx_t               cfg_index,
  input  logic [31:0]                     cfg_wdata
);

  // config registers
  logic [31:0]                    noise_seed_r;
  logic [vnf_pkg::BWRAP_W-1:0]    base_wrap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_seed_r <= vnf_pkg::SEED_RST;
      base_wrap_r  <= vnf_pkg::BWRAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vnf_pkg::CFG_NOISE_SEED: noise_seed_r <= cfg_wdata;
        vnf_pkg::CFG_BASE_WRAP:  base_wrap_r  <= cfg_wdata[vnf_pkg::BWRAP_W-1:0];
        default:                 ;
      endcase
    end
  end

  // fully pipelined, never stalls
  assign busy = 1'b0;

  // octave i: wrap = base_wrap << i, seed = noise_seed + i; sampled at entry
  vnf_pkg::oct_vec_t n_oct;

  for (genvar g = 0; g < vnf_pkg::OCT_CNT; g++) begin : g_oct
    logic [vnf_pkg::WRAP_W-1:0] wrap;
    logic [31:0]                seed;
    assign wrap = vnf_pkg::WRAP_W'(base_wrap_r) << g;
    assign seed = noise_seed_r + 32'(g);
    vnf_octave u_oct (
      .clk        (clk),
      .in_pixel_x (in_pixel_x),
      .in_pixel_y (in_pixel_y),
      .wrap_i     (wrap),
      .seed_i     (seed),
      .n_o        (n_oct[g])
    );
  end

  // valid bits alongside the five octave stages
  localparam int OCT_STG = 5;
  logic [OCT_STG-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[OCT_STG-2:0], start & ~busy};
    end
  end

  vnf_norm u_norm (
    .clk             (clk),
    .rst_n           (rst_n),
    .vld_i           (vld_r[OCT_STG-1]),
    .n_i             (n_oct),
    .out_valid       (out_valid),
    .out_noise_value (out_noise_value)
  );

endmodule

>>> bench/noise_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// noise_checker
// Watches requests and results of the value-noise block, predicts each
// texel value from its own copy of the registers and compares in order.
// ----------------------------------------------------------------------------
module noise_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic [7:0]          in_pixel_x,
  input  logic [7:0]          in_pixel_y,
  input  logic                out_valid,
  input  logic [7:0]          out_noise_value,
  input  logic                cfg_we,
  input  vnf_pkg::cfg_idx_t   cfg_index,
  input  logic [31:0]         cfg_wdata,
  output int                  fail_count,
  output int                  pending
);

  logic [31:0] seed_q;
  logic [4:0]  bwrap_q;
  logic [7:0]  texel_q[$];

  function automatic logic [31:0] lattice_hash(logic [31:0] x, logic [31:0] y,
                                               logic [31:0] s);
    logic [31:0] h;
    h = x * 32'd374761393 + y * 32'd668265263 + s * 32'd1013904223;
    h = (h ^ (h >> 13)) * 32'd1274126177;
    return h ^ (h >> 16);
  endfunction

  function automatic longint unsigned fade(longint unsigned t);
    return (t * t * (64'd196608 - 64'd2 * t)) >> 32;
  endfunction

  function automatic longint unsigned blend(longint unsigned a, longint unsigned b,
                                            longint unsigned w);
    return (a * (64'd65536 - w) + b * w) >> 16;
  endfunction

  function automatic logic [7:0] texel_value(logic [7:0] px, logic [7:0] py,
                                             logic [31:0] seed, logic [4:0] bw);
    longint unsigned total, wrap, pxs, pys, ix, iy, tx, ty, sx, sy, val;
    longint unsigned cx0, cy0, cx1, cy1, a, b, c, d;
    logic [31:0] s;
    total = 0;
    for (int i = 0; i < 4; i++) begin
      wrap = longint'(bw) << i;
      pxs = px * wrap;
      pys = py * wrap;
      cx0 = 0; cy0 = 0; cx1 = 0; cy1 = 0; tx = 0; ty = 0;
      if (wrap != 0) begin
        ix = pxs / 256;
        iy = pys / 256;
        tx = ((pxs % 256) << 16) / 256;
        ty = ((pys % 256) << 16) / 256;
        cx0 = ix % wrap;
        cy0 = iy % wrap;
        cx1 = (ix + 1) % wrap;
        cy1 = (iy + 1) % wrap;
      end
      sx = fade(tx);
      sy = fade(ty);
      s = seed + 32'(i);
      a = 64'(lattice_hash(32'(cx0), 32'(cy0), s) & 32'hffff);
      b = 64'(lattice_hash(32'(cx1), 32'(cy0), s) & 32'hffff);
      c = 64'(lattice_hash(32'(cx0), 32'(cy1), s) & 32'hffff);
      d = 64'(lattice_hash(32'(cx1), 32'(cy1), s) & 32'hffff);
      total += blend(blend(a, b, sx), blend(c, d, sx), sy) << (4 - i);
    end
    val = (total * 255) / (64'd2 * 64'd65535 * 64'd15);
    if (val > 255) val = 255;
    return val[7:0];
  endfunction

  assign pending = texel_q.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      seed_q     <= vnf_pkg::SEED_RST;
      bwrap_q    <= vnf_pkg::BWRAP_RST;
      fail_count <= 0;
      texel_q.delete();
    end else begin
      // registers change only when idle, so predicting with current values is safe
      if (start && !busy)
        texel_q.push_back(texel_value(in_pixel_x, in_pixel_y, seed_q, bwrap_q));
      if (out_valid) begin
        if (texel_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d",
                   $time, out_noise_value);
          fail_count <= fail_count + 1;
        end else begin
          if (texel_q[0] !== out_noise_value) begin
            $display("%0t: noise_value mismatch, expected %0d, actual %0d",
                     $time, texel_q[0], out_noise_value);
            fail_count <= fail_count + 1;
          end
          void'(texel_q.pop_front());
        end
      end
      if (cfg_we) begin
        if (cfg_index == vnf_pkg::CFG_NOISE_SEED) seed_q <= cfg_wdata;
        else if (cfg_index == vnf_pkg::CFG_BASE_WRAP) bwrap_q <= cfg_wdata[4:0];
      end
    end
  end
endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives texel requests in bursts over several seed / wrap settings and
// gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module testbench;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [7:0]        in_pixel_x = '0;
  logic [7:0]        in_pixel_y = '0;
  logic              out_valid;
  logic [7:0]        out_noise_value;
  logic              cfg_we = 1'b0;
  vnf_pkg::cfg_idx_t cfg_index = vnf_pkg::CFG_NOISE_SEED;
  logic [31:0]       cfg_wdata = '0;
  int                fail_count;
  int                pending;

  always #4 clk = ~clk;

  value_noise_fbm_generator DUT (.*);
  noise_checker u_checker (.*);

  // one register write, only issued while the pipe is drained
  task automatic write_reg(vnf_pkg::cfg_idx_t idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // present one request; hold start until accepted (busy is sampled at edge)
  task automatic send_texel(logic [7:0] x, logic [7:0] y);
    start      <= 1'b1;
    in_pixel_x <= x;
    in_pixel_y <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // wait for all requests to come back, then let the pipe settle with start low
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // random stream: bursts of back-to-back requests with random gaps
  task automatic random_texels(int n);
    int left, burst;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && left > 0; k++, left--)
        send_texel(8'($urandom), 8'($urandom));
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 9));
    end
  endtask

  initial begin
    logic [4:0] wraps[6];
    logic [31:0] seeds[6];
    wraps = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd7, 5'd4};
    seeds = '{32'd0, 32'hffff_ffff, 32'hffff_fffe, 32'd4242, 32'h0, 32'h0};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: reset settings, corners and edges of the texture
    send_texel(8'd0, 8'd0);
    send_texel(8'd255, 8'd255);
    send_texel(8'd0, 8'd255);
    send_texel(8'd255, 8'd0);
    send_texel(8'd63, 8'd64);
    send_texel(8'd64, 8'd63);
    send_texel(8'd128, 8'd127);
    send_texel(8'haa, 8'h55);
    send_texel(8'h55, 8'haa);
    drain();
    // zero wrap samples corner (0,0); wrap above sixteen used as given
    write_reg(vnf_pkg::CFG_BASE_WRAP, 32'd0);
    send_texel(8'd200, 8'd17);
    drain();
    write_reg(vnf_pkg::CFG_BASE_WRAP, 32'hffff_ffff);
    write_reg(vnf_pkg::CFG_NOISE_SEED, 32'hffff_fffd);   // seed+i wraps mod 2^32
    send_texel(8'd255, 8'd255);
    send_texel(8'd1, 8'd254);
    drain();
    random_texels(200);
    drain();
    // random phases over several settings, extremes among them
    for (int p = 0; p < 6; p++) begin
      write_reg(vnf_pkg::CFG_BASE_WRAP, p == 5 ? $urandom_range(1, 16) : 32'(wraps[p]));
      write_reg(vnf_pkg::CFG_NOISE_SEED, p >= 4 ? $urandom : seeds[p]);
      random_texels(170);
      drain();
    end
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end
endmodule

>>> sim.f
hw/rtl/vnf_pkg.sv
hw/rtl/vnf_octave.sv
hw/rtl/vnf_norm.sv
hw/rtl/value_noise_fbm_generator.sv
bench/noise_checker.sv
bench/testbench.sv
